/* hdl/nmf_pkg.sv */
// Shared types, constants and the rounding helper of the 3x3 neighbour mean filter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package nmf_pkg;

    localparam int CHAN_W     = 8;
    localparam int NCHAN      = 4;
    localparam int NFILT      = 3;     // channels that may be filtered
    localparam int SUM_W      = 11;    // eight 8-bit neighbours
    localparam int FW_W       = 13;
    localparam int FH_W       = 15;
    localparam int CC_W       = 3;
    localparam int ROW_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FH_W-1:0] HEIGHT_LIMIT = FH_W'(16384);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = FH_W'(480);
    localparam logic [CC_W-1:0] CHANNEL_COUNT_RST = CC_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [CHAN_W-1:0]            chan_t;
    typedef logic [NCHAN-1:0][CHAN_W-1:0] pixel_t;

    // one column of the window: top, middle and bottom pixel
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } col_t;

    // work handed from the sequencer to the window stage
    typedef struct packed {
        logic   emit;        // transaction produces a result
        logic   fend;        // result is the bottom-right pixel
        logic   flush_last;  // final drain: right column replicates the centre
        logic   slot;        // a new column enters the window
        logic   col_zero;    // new column is the first of its row
        logic   up_wr;       // write the upper line
        logic   mid_wr;      // write the middle line
        logic   top_mid;     // top of the new column replicates its middle
        logic   bot_mid;     // bottom of the new column replicates its middle
        logic   load_edge;   // single-row frame: preload window from column zero
        pixel_t pix;
    } cmd_t;

    // sum / 8, round to nearest, ties to even
    function automatic chan_t mean8(input logic [SUM_W-1:0] s);
        chan_t      q;
        logic [2:0] rem;
        logic       up;
        q   = s[SUM_W-1:3];
        rem = s[2:0];
        up  = (rem > 3'd4) || ((rem == 3'd4) && q[0]);
        return q + CHAN_W'(up);
    endfunction

endpackage

`default_nettype wire

/* hdl/neighbour_mean_3x3_filter.sv */
// Pipeline: the accepting edge registers the transaction for the window stage, which loads the result register.
// Throughput: one transaction per clock while no result stall holds the window stage; the line buffers are
// read at accept and written back from the window stage, with forwarding between them.
// Result stall holds the window stage and then the input, one stage deep.
// Reset: counters, window and result valid flag clear at once and configuration returns to
// 640 x 480 with four channels; the line buffers are not cleared and need no clearing pass.
`default_nettype none

module neighbour_mean_3x3_filter #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input pixel or flush transactions
    input  wire logic                              pix_valid,
    output logic                                   pix_stall,
    input  wire logic                              opcode,
    input  wire logic [nmf_pkg::CHAN_W-1:0]        chan0_in,
    input  wire logic [nmf_pkg::CHAN_W-1:0]        chan1_in,
    input  wire logic [nmf_pkg::CHAN_W-1:0]        chan2_in,
    input  wire logic [nmf_pkg::CHAN_W-1:0]        chan3_in,
    // filtered pixel transactions
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [nmf_pkg::CHAN_W-1:0]             chan0_out,
    output logic [nmf_pkg::CHAN_W-1:0]             chan1_out,
    output logic [nmf_pkg::CHAN_W-1:0]             chan2_out,
    output logic [nmf_pkg::CHAN_W-1:0]             chan3_out,
    output logic                                   last_of_run,
    output logic                                   frame_end,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [nmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [nmf_pkg::FW_W-1:0] frame_width_reg;
    logic [nmf_pkg::FH_W-1:0] frame_height_reg;
    logic [nmf_pkg::CC_W-1:0] channel_count_reg;

    logic            accept;
    logic            busy;
    nmf_pkg::pixel_t in_pix;
    nmf_pkg::cmd_t   cmd;
    logic [AW-1:0]   rd_addr;
    nmf_pkg::pixel_t up_rd, mid_rd;
    logic            up_wr_en, mid_wr_en;
    logic [AW-1:0]   wr_addr;
    nmf_pkg::pixel_t up_wr_data, mid_wr_data;
    nmf_pkg::pixel_t res_pix;

    // Configuration is always taken; writes to an unused index are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= nmf_pkg::FRAME_WIDTH_RST;
            frame_height_reg  <= nmf_pkg::FRAME_HEIGHT_RST;
            channel_count_reg <= nmf_pkg::CHANNEL_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nmf_pkg::CFG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data[nmf_pkg::FW_W-1:0];
                end
                nmf_pkg::CFG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data[nmf_pkg::FH_W-1:0];
                end
                nmf_pkg::CFG_CHANNEL_COUNT:
                begin
                    channel_count_reg <= cfg_data[nmf_pkg::CC_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold the input only while the window stage cannot hand its result on.
    assign pix_stall = busy;
    assign accept    = pix_valid && !busy;
    assign in_pix    = {chan3_in, chan2_in, chan1_in, chan0_in};

    // Stage 0: counters decide the action and issue the line buffer reads.
    nmf_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .opcode       (opcode),
        .pix          (in_pix),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .cmd          (cmd),
        .addr         (rd_addr)
    );

    // Two lines of history: upper and middle rows of the window.
    nmf_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (up_rd),
        .wr_en   (up_wr_en),
        .wr_addr (wr_addr),
        .wr_data (up_wr_data)
    );

    nmf_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mid_rd),
        .wr_en   (mid_wr_en),
        .wr_addr (wr_addr),
        .wr_data (mid_wr_data)
    );

    // Stage 1: modify and write back the lines, slide the window, form the mean.
    nmf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (cmd),
        .addr          (rd_addr),
        .up_rd         (up_rd),
        .mid_rd        (mid_rd),
        .channel_count (channel_count_reg),
        .res_stall     (res_stall),
        .busy          (busy),
        .up_wr_en      (up_wr_en),
        .mid_wr_en     (mid_wr_en),
        .wr_addr       (wr_addr),
        .up_wr_data    (up_wr_data),
        .mid_wr_data   (mid_wr_data),
        .res_valid     (res_valid),
        .res_pix       (res_pix),
        .res_fend      (frame_end)
    );

    assign chan0_out = res_pix[0];
    assign chan1_out = res_pix[1];
    assign chan2_out = res_pix[2];
    assign chan3_out = res_pix[3];

    // Every transaction gives at most one result, so each result ends its run.
    assign last_of_run = 1'b1;

endmodule

`default_nettype wire

/* hdl/nmf_line_mem.sv */
// One line buffer: single-port-write, single-port-read synchronous memory, registered read.
// Depends on nmf_pkg for the pixel type.
`default_nettype none

module nmf_line_mem #(
    parameter int DEPTH = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output nmf_pkg::pixel_t                            rd_data,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire nmf_pkg::pixel_t                       wr_data
);

    nmf_pkg::pixel_t mem [DEPTH];
    nmf_pkg::pixel_t rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/nmf_seq.sv */
// Sequencer: column, row and drain counters; turns each accepted transaction into a window command.
// Depends on nmf_pkg for the command type and register widths.
`default_nettype none

module nmf_seq #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        accept,
    input  wire logic                                        opcode,
    input  wire nmf_pkg::pixel_t                             pix,
    input  wire logic [nmf_pkg::FW_W-1:0]                    frame_width,
    input  wire logic [nmf_pkg::FH_W-1:0]                    frame_height,
    output nmf_pkg::cmd_t                                    cmd,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] addr
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int LW = (CW > nmf_pkg::FW_W) ? CW : nmf_pkg::FW_W;
    localparam int RW = nmf_pkg::ROW_W;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] pend_reg, pend_next;

    logic [LW-1:0] fw_ext;
    logic [LW-1:0] w_lim;
    logic [CW-1:0] w_eff;
    logic [nmf_pkg::FH_W-1:0] h_eff;
    logic          h_one;
    logic          restart;
    logic [CW-1:0] x;
    logic [RW-1:0] r;
    logic [CW:0]   x_inc;
    logic [RW:0]   r_inc;
    logic          row_end;
    logic          frame_done;
    logic [CW-1:0] sel_col;

    // clamp the frame size to what the line buffers can hold
    always_comb
    begin
        fw_ext = LW'(frame_width);
        if (fw_ext < LW'(2))
        begin
            w_lim = LW'(2);
        end
        else if (fw_ext > LW'(MAX_WIDTH))
        begin
            w_lim = LW'(MAX_WIDTH);
        end
        else
        begin
            w_lim = fw_ext;
        end
        w_eff = w_lim[CW-1:0];

        if (frame_height == '0)
        begin
            h_eff = nmf_pkg::FH_W'(1);
        end
        else if (frame_height > nmf_pkg::HEIGHT_LIMIT)
        begin
            h_eff = nmf_pkg::HEIGHT_LIMIT;
        end
        else
        begin
            h_eff = frame_height;
        end
        h_one = (h_eff == nmf_pkg::FH_W'(1));
    end

    // a pixel arriving while a drain is pending starts a new frame
    always_comb
    begin
        restart    = (pend_reg != '0);
        x          = restart ? '0 : col_reg;
        r          = restart ? '0 : row_reg;
        x_inc      = (CW + 1)'(x) + (CW + 1)'(1);
        r_inc      = (RW + 1)'(r) + (RW + 1)'(1);
        row_end    = (x_inc >= (CW + 1)'(w_eff));
        frame_done = row_end && (r_inc >= (RW + 1)'(h_eff));
    end

    always_comb
    begin
        cmd       = '0;
        cmd.pix   = pix;
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        sel_col   = col_reg;

        if (opcode == nmf_pkg::OP_PIXEL)
        begin
            sel_col      = x;
            cmd.mid_wr   = 1'b1;
            cmd.up_wr    = (r != '0);
            cmd.slot     = (r != '0);
            cmd.col_zero = (x == '0);
            cmd.top_mid  = (r == RW'(1));
            cmd.emit     = (r != '0) && ((x != '0) || (r >= RW'(2)));
            pend_next    = '0;
            row_next     = r;
            if (row_end)
            begin
                col_next = '0;
                if (frame_done)
                begin
                    row_next = '0;
                    if (h_one)
                    begin
                        cmd.load_edge = 1'b1;
                        col_next      = CW'(1);
                        pend_next     = PW'(w_eff);
                    end
                    else
                    begin
                        pend_next = PW'(w_eff) + PW'(1);
                    end
                end
                else
                begin
                    row_next = r_inc[RW-1:0];
                end
            end
            else
            begin
                col_next = x_inc[CW-1:0];
            end
        end
        else if (pend_reg == PW'(1))
        begin
            cmd.flush_last = 1'b1;
            cmd.emit       = 1'b1;
            cmd.fend       = 1'b1;
            pend_next      = '0;
            col_next       = '0;
        end
        else if (pend_reg != '0)
        begin
            cmd.slot     = 1'b1;
            cmd.col_zero = (col_reg == '0);
            cmd.emit     = 1'b1;
            cmd.top_mid  = h_one;
            cmd.bot_mid  = 1'b1;
            col_next     = col_reg + CW'(1);
            pend_next    = pend_reg - PW'(1);
        end
    end

    assign addr = sel_col[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PW'(MAX_WIDTH + 1))
        else $error("drain count beyond one line plus one");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(MAX_WIDTH))
        else $error("column counter beyond line buffer depth");

    a_drain_row: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0) |-> (row_reg == '0))
        else $error("drain pending with row counter not at frame start");

endmodule

`default_nettype wire

/* hdl/nmf_window.sv */
// Window stage: read-modify-write of the line buffers with forwarding, the two-column window,
// the eight-neighbour mean and the result register. Depends on nmf_pkg.
`default_nettype none

module nmf_window #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        accept,
    input  wire nmf_pkg::cmd_t                               cmd,
    input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] addr,
    input  wire nmf_pkg::pixel_t                             up_rd,
    input  wire nmf_pkg::pixel_t                             mid_rd,
    input  wire logic [nmf_pkg::CC_W-1:0]                    channel_count,
    input  wire logic                                        res_stall,
    output logic                                             busy,
    output logic                                             up_wr_en,
    output logic                                             mid_wr_en,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr,
    output nmf_pkg::pixel_t                                  up_wr_data,
    output nmf_pkg::pixel_t                                  mid_wr_data,
    output logic                                             res_valid,
    output nmf_pkg::pixel_t                                  res_pix,
    output logic                                             res_fend
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic            s1_valid_reg;
    nmf_pkg::cmd_t   s1_cmd_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic            fwd_up_hit_reg, fwd_mid_hit_reg;
    nmf_pkg::pixel_t fwd_up_data_reg, fwd_mid_data_reg;
    nmf_pkg::pixel_t shadow_reg;
    nmf_pkg::col_t   win_left_reg, win_right_reg;
    logic            res_valid_reg;
    nmf_pkg::pixel_t res_pix_reg;
    logic            res_fend_reg;

    logic            s1_fire;
    nmf_pkg::pixel_t mid_old, top_old, edge_pix;
    nmf_pkg::col_t   col_new, right, edge_col;
    nmf_pkg::pixel_t result;
    logic [nmf_pkg::SUM_W-1:0] sum;

    assign s1_fire = s1_valid_reg && (!s1_cmd_reg.emit || !res_valid_reg || !res_stall);
    assign busy    = s1_valid_reg && !s1_fire;

    // take the line data from the forwarding registers when the previous transaction wrote it
    always_comb
    begin
        mid_old     = fwd_mid_hit_reg ? fwd_mid_data_reg : mid_rd;
        top_old     = fwd_up_hit_reg ? fwd_up_data_reg : up_rd;
        col_new.top = s1_cmd_reg.top_mid ? mid_old : top_old;
        col_new.mid = mid_old;
        col_new.bot = s1_cmd_reg.bot_mid ? mid_old : s1_cmd_reg.pix;
        right       = (s1_cmd_reg.slot && !s1_cmd_reg.col_zero) ? col_new : win_right_reg;
        edge_pix    = (s1_cmd_reg.mid_wr && (s1_addr_reg == '0)) ? s1_cmd_reg.pix : shadow_reg;
        edge_col.top = edge_pix;
        edge_col.mid = edge_pix;
        edge_col.bot = edge_pix;
    end

    always_comb
    begin
        result = win_right_reg.mid;
        sum    = '0;
        for (int k = 0; k < nmf_pkg::NFILT; k++)
        begin
            sum = nmf_pkg::SUM_W'(win_left_reg.top[k]) + nmf_pkg::SUM_W'(win_left_reg.mid[k])
                + nmf_pkg::SUM_W'(win_left_reg.bot[k]) + nmf_pkg::SUM_W'(win_right_reg.top[k])
                + nmf_pkg::SUM_W'(win_right_reg.bot[k]) + nmf_pkg::SUM_W'(right.top[k])
                + nmf_pkg::SUM_W'(right.mid[k]) + nmf_pkg::SUM_W'(right.bot[k]);
            if (channel_count > nmf_pkg::CC_W'(k))
            begin
                result[k] = nmf_pkg::mean8(sum);
            end
        end
    end

    assign up_wr_en    = s1_fire && s1_cmd_reg.up_wr;
    assign mid_wr_en   = s1_fire && s1_cmd_reg.mid_wr;
    assign wr_addr     = s1_addr_reg;
    assign up_wr_data  = mid_old;
    assign mid_wr_data = s1_cmd_reg.pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fwd_up_hit_reg  <= 1'b0;
            fwd_mid_hit_reg <= 1'b0;
            win_left_reg    <= '0;
            win_right_reg   <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg    <= 1'b1;
                fwd_up_hit_reg  <= up_wr_en && (s1_addr_reg == addr);
                fwd_mid_hit_reg <= mid_wr_en && (s1_addr_reg == addr);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            // advance the window; a single-row frame end then reloads it from column zero
            if (s1_fire)
            begin
                if (s1_cmd_reg.load_edge)
                begin
                    win_left_reg  <= edge_col;
                    win_right_reg <= edge_col;
                end
                else if (s1_cmd_reg.slot)
                begin
                    win_left_reg  <= s1_cmd_reg.col_zero ? col_new : win_right_reg;
                    win_right_reg <= col_new;
                end
            end

            if (s1_fire && s1_cmd_reg.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg       <= cmd;
            s1_addr_reg      <= addr;
            fwd_up_data_reg  <= mid_old;
            fwd_mid_data_reg <= s1_cmd_reg.pix;
        end
        if (mid_wr_en && (s1_addr_reg == '0))
        begin
            shadow_reg <= s1_cmd_reg.pix;
        end
        if (s1_fire && s1_cmd_reg.emit)
        begin
            res_pix_reg  <= result;
            res_fend_reg <= s1_cmd_reg.fend;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_pix   = res_pix_reg;
    assign res_fend  = res_fend_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> s1_valid_reg)
        else $error("blocked window stage lost its transaction");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_cmd_reg.emit) |=> res_valid_reg)
        else $error("emitted result missing from result register");

    a_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a transaction in the window stage");

endmodule

`default_nettype wire
